FILE: src/mchs_pkg.sv
// ----------------------------------------------------------------------------
// mchs_pkg: modem connect handshake sequencer definitions
// Field widths, register indexes, and codes for phases, events,
// link actions, timer commands and done status.
// ----------------------------------------------------------------------------
package mchs_pkg;

	localparam int CMD_W    = 3;
	localparam int PHASE_W  = 3;
	localparam int RETRY_W  = 5;
	localparam int MAXR_W   = 4;
	localparam int TMR_W    = 16;
	localparam int LACT_W   = 3;
	localparam int TACT_W   = 2;
	localparam int DONE_W   = 2;
	localparam int CFGIDX_W = 2;
	localparam int CFGDAT_W = 16;

	// register indexes
	localparam logic [CFGIDX_W-1:0] REG_MAX_RETRIES     = 2'd0;
	localparam logic [CFGIDX_W-1:0] REG_CONNECT_TIMEOUT = 2'd1;
	localparam logic [CFGIDX_W-1:0] REG_ABSORB_TIMEOUT  = 2'd2;

	localparam logic [MAXR_W-1:0] MAX_RETRIES_RST     = 4'd3;
	localparam logic [TMR_W-1:0]  CONNECT_TIMEOUT_RST = 16'd1000;
	localparam logic [TMR_W-1:0]  ABSORB_TIMEOUT_RST  = 16'd200;

	localparam logic [RETRY_W-1:0] RETRY_SAT = 5'd31;

	// phases
	localparam logic [PHASE_W-1:0] PH_CLOSED  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_WAITACK = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RECEIVE = 3'd2;
	localparam logic [PHASE_W-1:0] PH_STATUS  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ADDRESS = 3'd4;
	localparam logic [PHASE_W-1:0] PH_VERSION = 3'd5;
	localparam logic [PHASE_W-1:0] PH_RESET   = 3'd6;

	// events
	localparam logic [CMD_W-1:0] EV_OPEN    = 3'd0;
	localparam logic [CMD_W-1:0] EV_TIMEOUT = 3'd1;
	localparam logic [CMD_W-1:0] EV_ACK     = 3'd2;
	localparam logic [CMD_W-1:0] EV_RXMSG   = 3'd3;
	localparam logic [CMD_W-1:0] EV_STATUS  = 3'd4;
	localparam logic [CMD_W-1:0] EV_ADDRESS = 3'd5;
	localparam logic [CMD_W-1:0] EV_VERSION = 3'd6;

	// link actions
	localparam logic [LACT_W-1:0] LA_NONE    = 3'd0;
	localparam logic [LACT_W-1:0] LA_OPEN    = 3'd1;
	localparam logic [LACT_W-1:0] LA_RESET   = 3'd2;
	localparam logic [LACT_W-1:0] LA_STATUS  = 3'd3;
	localparam logic [LACT_W-1:0] LA_ADDRESS = 3'd4;
	localparam logic [LACT_W-1:0] LA_VERSION = 3'd5;
	localparam logic [LACT_W-1:0] LA_CONNECT = 3'd6;
	localparam logic [LACT_W-1:0] LA_CLOSE   = 3'd7;

	// timer commands
	localparam logic [TACT_W-1:0] TA_KEEP    = 2'd0;
	localparam logic [TACT_W-1:0] TA_STOP    = 2'd1;
	localparam logic [TACT_W-1:0] TA_CONNECT = 2'd2;
	localparam logic [TACT_W-1:0] TA_ABSORB  = 2'd3;

	// done status
	localparam logic [DONE_W-1:0] DONE_NONE = 2'd0;
	localparam logic [DONE_W-1:0] DONE_OK   = 2'd1;
	localparam logic [DONE_W-1:0] DONE_ERR  = 2'd2;

	function automatic logic [RETRY_W-1:0] sat_inc(input logic [RETRY_W-1:0] v);
		sat_inc = (v == RETRY_SAT) ? RETRY_SAT : v + 1'b1;
	endfunction

endpackage

FILE: src/modem_connect_handshake_fsm.sv
// ----------------------------------------------------------------------------
// modem_connect_handshake_fsm: serial modem connect handshake sequencer
// Each accepted input's result is loaded into the output register.
// Throughput: one event per cycle while the output is not stalled; the phase/retry
// update and the result decode sit in one combinational pass ahead of the output register.
// Reset: phase closed, retry count zero, registers at their defaults
// (max_retries 3, connect_timeout 1000, absorb_timeout 200), output empty.
// ----------------------------------------------------------------------------
module modem_connect_handshake_fsm (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mchs_pkg::CMD_W-1:0]      cmd,
	input  logic                            link_open,
	input  logic                            open_failed,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mchs_pkg::LACT_W-1:0]     link_action,
	output logic [mchs_pkg::TACT_W-1:0]     timer_action,
	output logic [mchs_pkg::TMR_W-1:0]      timer_load,
	output logic [mchs_pkg::DONE_W-1:0]     done_code,
	output logic [mchs_pkg::PHASE_W-1:0]    state_now,
	input  logic                            cfg_we,
	input  logic [mchs_pkg::CFGIDX_W-1:0]   cfg_index,
	input  logic [mchs_pkg::CFGDAT_W-1:0]   cfg_data
);
	import mchs_pkg::*;

	logic [MAXR_W-1:0]  max_retries_q;
	logic [TMR_W-1:0]   connect_timeout_q;
	logic [TMR_W-1:0]   absorb_timeout_q;
	logic [PHASE_W-1:0] phase_q;
	logic [RETRY_W-1:0] retry_q;
	logic               out_valid_q;
	logic [LACT_W-1:0]  link_action_q;
	logic [TACT_W-1:0]  timer_action_q;
	logic [TMR_W-1:0]   timer_load_q;
	logic [DONE_W-1:0]  done_code_q;

	logic               accept;
	logic [PHASE_W-1:0] phase_nx;
	logic [RETRY_W-1:0] retry_nx;
	logic [RETRY_W-1:0] retry_inc;
	logic [RETRY_W-1:0] max_ext;
	logic [LACT_W-1:0]  la;
	logic [TACT_W-1:0]  ta;
	logic [DONE_W-1:0]  done;
	logic [TMR_W-1:0]   load;
	logic               absorb_ev;

	// output register frees up as it is taken, so input flows every cycle unless the output stalls
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign max_ext   = {1'b0, max_retries_q};
	assign retry_inc = sat_inc(retry_q);
	assign absorb_ev = (cmd == EV_ACK) || (cmd == EV_RXMSG);

	always_comb begin
		phase_nx = phase_q;
		retry_nx = retry_q;
		la       = LA_NONE;
		ta       = TA_KEEP;
		done     = DONE_NONE;
		case (phase_q)
			PH_CLOSED: begin
				if (cmd == EV_OPEN) begin
					la = LA_OPEN;
					if (open_failed) begin
						done = DONE_ERR;
					end else begin
						phase_nx = PH_WAITACK;
						ta       = TA_CONNECT;
					end
				end
			end
			PH_WAITACK: begin
				if (cmd == EV_ACK) begin
					retry_nx = '0;
					phase_nx = PH_RECEIVE;
					ta       = TA_CONNECT;
				end else if (cmd == EV_TIMEOUT) begin
					if (retry_q < max_ext) begin
						if (!link_open)
							la = LA_OPEN;
						ta = TA_CONNECT;
					end else if (retry_q == max_ext) begin
						la       = LA_RESET;
						ta       = TA_CONNECT;
						phase_nx = PH_RESET;
					end else begin
						// past the reset attempt: give up, timer left running
						la   = LA_CLOSE;
						done = DONE_ERR;
					end
					retry_nx = retry_inc;
				end
			end
			PH_RECEIVE: begin
				if (absorb_ev) begin
					ta = TA_ABSORB;
				end else if (cmd == EV_TIMEOUT) begin
					retry_nx = '0;
					la       = LA_STATUS;
					phase_nx = PH_STATUS;
					ta       = TA_CONNECT;
				end
			end
			PH_STATUS, PH_ADDRESS: begin
				if (absorb_ev) begin
					retry_nx = '0;
					ta       = TA_ABSORB;
				end else if (cmd == EV_TIMEOUT) begin
					retry_nx = retry_inc;
					if (retry_q < max_ext) begin
						la = (phase_q == PH_STATUS) ? LA_STATUS : LA_ADDRESS;
						ta = TA_CONNECT;
					end else begin
						la   = LA_CLOSE;
						ta   = TA_STOP;
						done = DONE_ERR;
					end
				end else if (phase_q == PH_STATUS && cmd == EV_STATUS) begin
					la       = LA_ADDRESS;
					phase_nx = PH_ADDRESS;
					ta       = TA_CONNECT;
				end else if (phase_q == PH_ADDRESS && cmd == EV_ADDRESS) begin
					retry_nx = '0;
					la       = LA_VERSION;
					phase_nx = PH_VERSION;
					ta       = TA_CONNECT;
				end
			end
			PH_VERSION: begin
				if (absorb_ev) begin
					retry_nx = '0;
					ta       = TA_ABSORB;
				end else if (cmd == EV_VERSION) begin
					retry_nx = '0;
					ta       = TA_STOP;
					done     = DONE_OK;
				end else if (cmd == EV_TIMEOUT) begin
					// compare uses the already incremented count
					if (retry_inc < max_ext) begin
						retry_nx = retry_inc;
						la       = LA_VERSION;
						ta       = TA_CONNECT;
					end else begin
						retry_nx = '0;
						ta       = TA_STOP;
						done     = DONE_OK;
					end
				end
			end
			PH_RESET: begin
				if (cmd == EV_TIMEOUT) begin
					la       = LA_CONNECT;
					phase_nx = PH_WAITACK;
					ta       = TA_CONNECT;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		case (ta)
			TA_CONNECT: load = connect_timeout_q;
			TA_ABSORB:  load = absorb_timeout_q;
			default:    load = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_retries_q     <= MAX_RETRIES_RST;
			connect_timeout_q <= CONNECT_TIMEOUT_RST;
			absorb_timeout_q  <= ABSORB_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_RETRIES:     max_retries_q     <= cfg_data[MAXR_W-1:0];
				REG_CONNECT_TIMEOUT: connect_timeout_q <= cfg_data[TMR_W-1:0];
				REG_ABSORB_TIMEOUT:  absorb_timeout_q  <= cfg_data[TMR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CLOSED;
			retry_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_nx;
				retry_q <= retry_nx;
			end
			if (accept)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// result payload, loaded on each transfer in
	always_ff @(posedge clk) begin
		if (accept) begin
			link_action_q  <= la;
			timer_action_q <= ta;
			timer_load_q   <= load;
			done_code_q    <= done;
		end
	end

	assign out_valid    = out_valid_q;
	assign link_action  = link_action_q;
	assign timer_action = timer_action_q;
	assign timer_load   = timer_load_q;
	assign done_code    = done_code_q;
	assign state_now    = phase_q;

	a_reset_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && link_action_q == LA_RESET |-> phase_q == PH_RESET)
		else $error("modem reset issued outside reset phase");

	a_done_ok_version: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_code_q == DONE_OK |-> phase_q == PH_VERSION)
		else $error("done-ok outside version phase");

	a_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (timer_action_q == TA_KEEP || timer_action_q == TA_STOP)
		|-> timer_load_q == '0)
		else $error("timer load set without a restart");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(phase_q) && $stable(retry_q))
		else $error("state changed without a transfer");

	a_no_phase7: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_RESET)
		else $error("unused phase code reached");

endmodule
